// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int DEF_ARENA_MAX_BYTES   = 4096;
  localparam int DEF_HDR_BYTES         = 32;
  localparam int DEF_MIN_SPLIT_PAYLOAD = 64;
  localparam int DEF_MAX_CHUNKS        = 128;

  localparam int ARENA_MIN_BYTES   = 128;
  localparam int ARENA_RESET_BYTES = 4096;

  localparam int REQ_W  = 13;
  localparam int ADDR_W = 12;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 13;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic              init;
    logic              latch;
    logic              scan;
    logic              act;
    logic              shift;
    logic              tail;
    logic              res_en;
    logic [STAT_W-1:0] res_status;
  } ffa_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic is_free;
    logic split;
    logic shift_done;
  } ffa_sts_t;

endpackage

// ===== rtl/first_fit_arena_allocator.sv =====
// one word in flight; busy drops in the cycle out_valid marks the result word
// alloc: the scan finds the first fit, the update writes the entry, and a split adds a shift and a tail write
// free: the scan finds the block, the update merges free neighbours, and a shift closes up the table
// the scan reads one table entry per cycle
// the receiver cannot stall: out_valid marks the result word for one cycle
// after reset the init state writes the single free chunk; busy is high meanwhile
module first_fit_arena_allocator import ffa_pkg::*; #(
  parameter int ARENA_MAX_BYTES   = DEF_ARENA_MAX_BYTES,
  parameter int HDR_BYTES         = DEF_HDR_BYTES,
  parameter int MIN_SPLIT_PAYLOAD = DEF_MIN_SPLIT_PAYLOAD,
  parameter int MAX_CHUNKS        = DEF_MAX_CHUNKS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic              in_op,
  input  logic [REQ_W-1:0]  in_req_size,
  input  logic [ADDR_W-1:0] in_block_addr,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_addr
);

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffa_datapath #(
    .ARENA_MAX_BYTES   (ARENA_MAX_BYTES),
    .HDR_BYTES         (HDR_BYTES),
    .MIN_SPLIT_PAYLOAD (MIN_SPLIT_PAYLOAD),
    .MAX_CHUNKS        (MAX_CHUNKS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_op),
    .in_req_size   (in_req_size),
    .in_block_addr (in_block_addr),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_addr      (out_addr)
  );

endmodule

// ===== rtl/ffa_ctrl.sv =====
module ffa_ctrl import ffa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output ffa_cmd_t cmd,
  input  ffa_sts_t sts
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_ACT;
        end else if (sts.last) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = sts.is_free ? ST_BADFREE : ST_OOM;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ACT: begin
        cmd.act = 1'b1;
        if (!sts.is_free && !sts.split) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          if (sts.is_free) begin
            cmd.res_en     = 1'b1;
            cmd.res_status = ST_OK;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        cmd.tail       = 1'b1;
        cmd.res_en     = 1'b1;
        cmd.res_status = ST_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) != S_IDLE)
    else $error("result word without a preceding operation");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start an operation");

  a_shift_from_act: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && $past(state_r) != S_SHIFT) |-> $past(state_r) == S_ACT)
    else $error("shift entered without a table update");

endmodule

// ===== rtl/ffa_datapath.sv =====
module ffa_datapath import ffa_pkg::*; #(
  parameter int ARENA_MAX_BYTES   = DEF_ARENA_MAX_BYTES,
  parameter int HDR_BYTES         = DEF_HDR_BYTES,
  parameter int MIN_SPLIT_PAYLOAD = DEF_MIN_SPLIT_PAYLOAD,
  parameter int MAX_CHUNKS        = DEF_MAX_CHUNKS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_op,
  input  logic [REQ_W-1:0]  in_req_size,
  input  logic [ADDR_W-1:0] in_block_addr,
  input  ffa_cmd_t          cmd,
  output ffa_sts_t          sts,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_addr
);

  localparam int AW = $clog2(ARENA_MAX_BYTES + 1);
  localparam int WW = (AW > REQ_W) ? AW : REQ_W;
  localparam int XW = WW + 1;
  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int EW = 2 * AW + 1;
  localparam int RST_ARENA = (ARENA_MAX_BYTES < ARENA_RESET_BYTES) ?
                             ARENA_MAX_BYTES : ARENA_RESET_BYTES;

  localparam logic [XW-1:0] HDR_X   = XW'(HDR_BYTES);
  localparam logic [XW-1:0] SPLIT_X = XW'(HDR_BYTES + MIN_SPLIT_PAYLOAD);
  localparam logic [XW-1:0] MIN_X   = XW'(ARENA_MIN_BYTES);
  localparam logic [XW-1:0] MAX_X   = XW'(ARENA_MAX_BYTES);

  // entry word: {free, payload size, header offset}
  logic [EW-1:0] mem [MAX_CHUNKS];
  logic [EW-1:0] rdata_r;

  logic [AW-1:0]     arena_r;
  logic [CW-1:0]     cnt_r;
  logic              op_r;
  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] baddr_r;
  logic [CW-1:0]     rp_r;
  logic              ev_r;
  logic [CW-1:0]     ep_r;
  logic [EW-1:0]     prev_r;
  logic [EW-1:0]     hit_r;
  logic [IW-1:0]     hi_r;
  logic [CW-1:0]     n_r;
  logic              mv_r;
  logic [IW-1:0]     ms_r;
  logic              up_r;
  logic [1:0]        d_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic [XW-1:0] cfg_x, arena_cfg_x, req_x, left_x, msize_x, a_addr_x;
  logic [AW-1:0] c_start, c_size, h_start, h_size, p_start, p_size, mstart;
  logic          c_free, p_free, match_a, match_f, hit, split, pf, nf;
  logic [1:0]    d_nxt;
  logic [CW-1:0] src, hi_c;
  logic [IW-1:0] dst;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  always_comb begin
    cfg_x = XW'(cfg_wdata);
    if (cfg_x < MIN_X) begin
      arena_cfg_x = MIN_X;
    end else if (cfg_x > MAX_X) begin
      arena_cfg_x = MAX_X;
    end else begin
      arena_cfg_x = cfg_x;
    end
  end

  assign c_start = rdata_r[AW-1:0];
  assign c_size  = rdata_r[2*AW-1:AW];
  assign c_free  = rdata_r[2*AW];
  assign h_start = hit_r[AW-1:0];
  assign h_size  = hit_r[2*AW-1:AW];
  assign p_start = prev_r[AW-1:0];
  assign p_size  = prev_r[2*AW-1:AW];
  assign p_free  = prev_r[2*AW];
  assign req_x   = XW'(req_r);
  assign hi_c    = CW'(hi_r);

  assign match_a = c_free && (req_x <= XW'(c_size));
  assign match_f = !c_free && ((XW'(c_start) + HDR_X) == XW'(baddr_r));
  assign hit     = ev_r && ((op_r == OP_ALLOC) ? match_a : match_f);

  assign left_x   = XW'(h_size) - req_x;
  assign split    = (left_x >= SPLIT_X) && (cnt_r < CW'(MAX_CHUNKS));
  assign a_addr_x = XW'(h_start) + HDR_X;

  // during the update cycle the read register holds the entry after the hit
  assign pf      = (hi_r != '0) && p_free;
  assign nf      = ((hi_c + CW'(1)) < cnt_r) && c_free;
  assign msize_x = (pf ? (XW'(p_size) + HDR_X) : '0) + XW'(h_size) +
                   (nf ? (HDR_X + XW'(c_size)) : '0);
  assign mstart  = pf ? p_start : h_start;
  assign dst     = pf ? (hi_r - IW'(1)) : hi_r;
  assign d_nxt   = {1'b0, pf} + {1'b0, nf};
  assign src     = hi_c + CW'(1) + CW'(nf);

  assign sts.hit        = hit;
  assign sts.last       = ev_r && (ep_r == (cnt_r - CW'(1)));
  assign sts.is_free    = (op_r == OP_FREE);
  assign sts.split      = split;
  assign sts.shift_done = (n_r == '0) && !mv_r;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = rp_r[IW-1:0];
    if (cfg_we) begin
      we    = 1'b1;
      wdata = {1'b1, AW'(arena_cfg_x - HDR_X), {AW{1'b0}}};
    end else if (cmd.init) begin
      we    = 1'b1;
      wdata = {1'b1, AW'(XW'(arena_r) - HDR_X), {AW{1'b0}}};
    end else if (cmd.act) begin
      we = 1'b1;
      if (op_r == OP_ALLOC) begin
        waddr = hi_r;
        wdata = {1'b0, (split ? AW'(req_x) : h_size), h_start};
      end else begin
        waddr = dst;
        wdata = {1'b1, AW'(msize_x), mstart};
      end
    end else if (cmd.tail) begin
      we    = 1'b1;
      waddr = IW'(hi_c + CW'(1));
      wdata = {1'b1, AW'(left_x - HDR_X), AW'(a_addr_x + req_x)};
    end else if (cmd.shift && mv_r) begin
      we    = 1'b1;
      waddr = up_r ? IW'(CW'(ms_r) + CW'(1)) : IW'(CW'(ms_r) - CW'(d_r));
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r <= AW'(RST_ARENA);
      cnt_r   <= CW'(1);
      rp_r    <= '0;
      ev_r    <= 1'b0;
      n_r     <= '0;
      mv_r    <= 1'b0;
    end else begin
      ev_r <= cmd.scan;
      mv_r <= cmd.shift && (n_r != '0);
      if (cfg_we) begin
        arena_r <= AW'(arena_cfg_x);
        cnt_r   <= CW'(1);
      end
      if (cmd.init) begin
        cnt_r <= CW'(1);
      end
      if (cmd.latch) begin
        rp_r <= '0;
      end
      if (cmd.scan) begin
        rp_r <= rp_r + CW'(1);
        ep_r <= rp_r;
        if (ev_r) begin
          if (hit) begin
            hit_r <= rdata_r;
            hi_r  <= ep_r[IW-1:0];
          end else begin
            prev_r <= rdata_r;
          end
        end
      end
      if (cmd.act) begin
        if (op_r == OP_ALLOC) begin
          up_r <= 1'b1;
          d_r  <= 2'd1;
          if (split) begin
            rp_r <= cnt_r - CW'(1);
            n_r  <= cnt_r - CW'(1) - hi_c;
          end else begin
            n_r <= '0;
          end
        end else begin
          up_r  <= 1'b0;
          d_r   <= d_nxt;
          rp_r  <= src;
          n_r   <= cnt_r - src;
          cnt_r <= cnt_r - CW'(d_nxt);
        end
      end
      // one entry moves per cycle, read ahead of the write
      if (cmd.shift && (n_r != '0)) begin
        rp_r <= up_r ? (rp_r - CW'(1)) : (rp_r + CW'(1));
        n_r  <= n_r - CW'(1);
        ms_r <= rp_r[IW-1:0];
      end
      if (cmd.tail) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_op;
      req_r   <= in_req_size;
      baddr_r <= in_block_addr;
    end
    if (cmd.res_en) begin
      out_status_r <= cmd.res_status;
      out_addr_r   <= ((cmd.res_status == ST_OK) && (op_r == OP_ALLOC)) ?
                      a_addr_x[ADDR_W-1:0] : '0;
    end
  end

  assign out_status = out_status_r;
  assign out_addr   = out_addr_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CW'(MAX_CHUNKS)))
    else $error("chunk count out of range");

  a_tail_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tail |-> (cnt_r < CW'(MAX_CHUNKS)))
    else $error("split with a full chunk table");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import ffa_pkg::*;

  localparam int HDR       = DEF_HDR_BYTES;
  localparam int MIN_SPLIT = DEF_MIN_SPLIT_PAYLOAD;
  localparam int MAXC      = DEF_MAX_CHUNKS;
  localparam int LIMIT     = 2000000;
  localparam int DRAIN     = 2 * MAXC + 20;

  typedef struct packed {
    logic              op;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] block_addr;
  } word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_op = 1'b0;
  logic [REQ_W-1:0]  in_req_size = '0;
  logic [ADDR_W-1:0] in_block_addr = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_addr;

  first_fit_arena_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_op(in_op), .in_req_size(in_req_size),
    .in_block_addr(in_block_addr), .out_valid(out_valid),
    .out_status(out_status), .out_addr(out_addr)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // chunk table mirror
  int unsigned arena_sz;
  int unsigned c_start[MAXC];
  int unsigned c_size[MAXC];
  bit          c_free[MAXC];
  int unsigned c_cnt;
  int unsigned live_addrs[$];

  word_t   pending_words[$];
  result_t expected_results[$];
  int      mismatches = 0;
  longint  cycles = 0;

  function automatic void arena_init(int unsigned v);
    arena_sz = (v < ARENA_MIN_BYTES) ? ARENA_MIN_BYTES :
               (v > DEF_ARENA_MAX_BYTES) ? DEF_ARENA_MAX_BYTES : v;
    c_cnt = 1;
    c_start[0] = 0;
    c_size[0] = arena_sz - HDR;
    c_free[0] = 1'b1;
    live_addrs.delete();
  endfunction

  function automatic void drop_chunk(int unsigned i);
    for (int unsigned k = i; k + 1 < c_cnt; k++) begin
      c_start[k] = c_start[k+1];
      c_size[k]  = c_size[k+1];
      c_free[k]  = c_free[k+1];
    end
    c_cnt--;
  endfunction

  function automatic result_t predict_arena(word_t w);
    result_t r;
    int unsigned i;
    r.status = ST_OK;
    r.addr = '0;
    if (w.op == OP_ALLOC) begin
      for (i = 0; i < c_cnt; i++)
        if (c_free[i] && w.req_size <= c_size[i]) break;
      if (i >= c_cnt) begin
        r.status = ST_OOM;
        return r;
      end
      if (c_size[i] - w.req_size >= HDR + MIN_SPLIT && c_cnt < MAXC) begin
        for (int unsigned k = c_cnt; k > i + 1; k--) begin
          c_start[k] = c_start[k-1];
          c_size[k]  = c_size[k-1];
          c_free[k]  = c_free[k-1];
        end
        c_start[i+1] = c_start[i] + HDR + w.req_size;
        c_size[i+1]  = c_size[i] - w.req_size - HDR;
        c_free[i+1]  = 1'b1;
        c_size[i]    = w.req_size;
        c_cnt++;
      end
      c_free[i] = 1'b0;
      r.addr = ADDR_W'(c_start[i] + HDR);
      live_addrs.push_back(c_start[i] + HDR);
    end else begin
      for (i = 0; i < c_cnt; i++)
        if (!c_free[i] && c_start[i] + HDR == w.block_addr) break;
      if (i >= c_cnt) begin
        r.status = ST_BADFREE;
        return r;
      end
      foreach (live_addrs[j])
        if (live_addrs[j] == w.block_addr) begin
          live_addrs.delete(j);
          break;
        end
      c_free[i] = 1'b1;
      if (i > 0 && c_free[i-1]) begin
        c_size[i-1] += c_size[i] + HDR;
        drop_chunk(i);
        i--;
      end
      if (i + 1 < c_cnt && c_free[i+1]) begin
        c_size[i] += c_size[i+1] + HDR;
        drop_chunk(i + 1);
      end
    end
    return r;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(predict_arena(pending_words.pop_front()));
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (!(start && busy)) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          start <= 1'b1;
          in_op <= pending_words[0].op;
          in_req_size <= pending_words[0].req_size;
          in_block_addr <= pending_words[0].block_addr;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word status=%0d addr=%0d", out_status, out_addr);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (out_status !== e.status || out_addr !== e.addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d addr=%0d, got status=%0d addr=%0d",
                     e.status, e.addr, out_status, out_addr);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // queue a word; the random phase sends frees to live blocks mostly
  task automatic add_word(bit op, int unsigned sz, int unsigned a);
    word_t w;
    w.op = op;
    w.req_size = REQ_W'(sz);
    w.block_addr = ADDR_W'(a);
    pending_words.push_back(w);
  endtask

  // the mirror runs ahead at accept time, so wait for the block to drain
  task automatic settle();
    while (pending_words.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_arena(int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int unsigned max_sz);
    int unsigned sz, a, idx, kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        case ($urandom_range(0, 9))
          0: sz = $urandom_range(0, 8191);
          1: sz = 0;
          default: sz = $urandom_range(0, max_sz);
        endcase
        add_word(OP_ALLOC, sz, $urandom);
      end else if (kind < 90) begin
        // wait for the alloc results so the live list is current
        settle();
        if (live_addrs.size() > 0) begin
          idx = $urandom_range(0, live_addrs.size() - 1);
          a = live_addrs[idx];
        end else begin
          a = $urandom_range(0, 4095);
        end
        add_word(OP_FREE, $urandom, a);
      end else begin
        add_word(OP_FREE, $urandom, $urandom_range(0, 4095));
      end
    end
    settle();
  endtask

  initial begin
    arena_init(ARENA_RESET_BYTES);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    // directed: extremes, zero size, exact fit, oom, bad and double free
    add_word(OP_ALLOC, 0, 0);
    add_word(OP_ALLOC, 8191, 4095);
    add_word(OP_ALLOC, 4096, 0);
    add_word(OP_ALLOC, 100, 0);
    add_word(OP_ALLOC, 3000, 0);
    add_word(OP_FREE, 0, 4095);
    add_word(OP_FREE, 0, 0);
    add_word(OP_FREE, 8191, 32);
    add_word(OP_FREE, 0, 32);
    add_word(OP_FREE, 0, 164);
    add_word(OP_FREE, 0, 296);
    add_word(OP_ALLOC, 4064, 0);
    add_word(OP_ALLOC, 1, 0);
    add_word(OP_FREE, 0, 32);
    settle();
    // small arena and clamping
    write_arena(0);
    arena_init(0);
    add_word(OP_ALLOC, 96, 0);
    add_word(OP_ALLOC, 97, 0);
    add_word(OP_FREE, 0, 32);
    settle();
    write_arena(8191);
    arena_init(8191);
    // fill the arena with zero-size allocs until they run out of memory
    for (int k = 0; k < 140; k++) add_word(OP_ALLOC, 0, 0);
    settle();
    random_phase(250, 96);
    write_arena(4096);
    arena_init(4096);
    random_phase(350, 300);
    write_arena(128);
    arena_init(128);
    random_phase(100, 120);
    write_arena(1000 + $urandom_range(0, 2000));
    arena_init(cfg_wdata);
    random_phase(300, 600);
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
